// ----- design/nearest_track_association_macros.svh -----
// Assertion macros for the nearest track association block.
// Used by the top level; the including module must provide aclk and aresetn.
`ifndef NEAREST_TRACK_ASSOCIATION_MACROS_SVH
`define NEAREST_TRACK_ASSOCIATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/nta_pkg.sv -----
// Package for the nearest track association block: payload types, command and
// status structs, state and match codes, and fixed sizes. No dependencies.
package nta_pkg;

    localparam int MAX_TRACKS = 16;
    localparam int IDX_W      = $clog2(MAX_TRACKS);
    localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
    localparam int THR_W      = 11;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam int POS_W      = 12;
    localparam int SIZE_W     = 11;
    localparam int CTR_W      = 13;
    localparam int SUM_W      = CTR_W + 1;
    localparam int SQ_W       = 25;
    localparam int DIST_W     = SQ_W + 1;
    localparam int TID_W      = 5;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 11'd15;

    localparam logic [1:0] OP_FRAME_START = 2'd0;
    localparam logic [1:0] OP_DETECT      = 2'd1;
    localparam logic [1:0] OP_FRAME_END   = 2'd2;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [POS_W-1:0]  box_x;
        logic signed [POS_W-1:0]  box_y;
        logic [SIZE_W-1:0]        box_width;
        logic [SIZE_W-1:0]        box_height;
    } nta_in_t;

    typedef struct packed {
        logic [TID_W-1:0] track_id;
        logic             is_new;
        logic             table_full;
    } nta_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_SCAN,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_UPDATE
    } nta_state_t;

    typedef enum logic [1:0] {
        MATCH_NONE,
        MATCH_ONE,
        MATCH_MANY
    } nta_match_t;

    typedef struct packed {
        logic             load_in;
        logic             frame_start;
        logic             frame_end;
        logic             start_scan;
        logic             issue;
        logic [IDX_W-1:0] scan_idx;
        logic             update;
    } nta_cmd_t;

    typedef struct packed {
        logic out_free;
    } nta_status_t;

endpackage

// ----- design/nta_ctrl.sv -----
// Controller for the nearest track association block: sequences acceptance,
// the slot scan, the pipeline drain and the table update. Uses nta_pkg.
module nta_ctrl
    import nta_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic [1:0]  s_op,
    output logic        s_ready,
    input  nta_status_t status,
    output nta_cmd_t    cmd
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TRACKS - 1);

    nta_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_op == OP_DETECT) begin
                    state_next = ST_CENTRE;
                end
            end
            ST_CENTRE: begin
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN_A;
                end
            end
            ST_DRAIN_A: begin
                state_next = ST_DRAIN_B;
            end
            ST_DRAIN_B: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        cmd              = '0;
        cmd.scan_idx     = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready         = 1'b1;
                cmd.load_in     = s_valid;
                cmd.frame_start = s_valid && s_op == OP_FRAME_START;
                cmd.frame_end   = s_valid && s_op == OP_FRAME_END;
            end
            ST_CENTRE: begin
                cmd.start_scan = 1'b1;
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN_A, ST_DRAIN_B: begin
                cmd.issue = 1'b0;
            end
            ST_UPDATE: begin
                cmd.update = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/nta_datapath.sv -----
// Datapath for the nearest track association block: centre calculation, the
// track table, the distance pipeline, match tracking and the result register.
// Uses nta_pkg.
module nta_datapath
    import nta_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [THR_W-1:0] cfg_data,
    input  nta_in_t          s_payload,
    input  nta_cmd_t         cmd,
    output nta_status_t      status,
    input  logic             m_ready,
    output logic             m_valid,
    output nta_out_t         m_payload
);

    localparam logic [THR_SQ_W-1:0] THR_SQ_RESET =
        THR_SQ_W'(THRESHOLD_RESET) * THR_SQ_W'(THRESHOLD_RESET);

    function automatic logic signed [CTR_W-1:0] half_centre(
        input logic signed [POS_W-1:0] pos,
        input logic [SIZE_W-1:0]       size
    );
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] adj;
        sum = {pos[POS_W-1], pos, 1'b0} + {{(SUM_W-SIZE_W){1'b0}}, size};
        adj = sum + {{(SUM_W-1){1'b0}}, sum[SUM_W-1]};
        return adj[SUM_W-1:1];
    endfunction

    nta_in_t                  in_reg;
    logic signed [CTR_W-1:0]  cx_reg, cy_reg;
    logic [THR_SQ_W-1:0]      thr_sq_reg, thr_sq_next;
    logic [MAX_TRACKS-1:0]    active_reg, active_next;
    logic [MAX_TRACKS-1:0]    fresh_reg, fresh_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    logic [2*CTR_W-1:0]       centre_mem [MAX_TRACKS];
    logic [2*CTR_W-1:0]       rd_reg;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;

    logic                     a_vld_reg, b_vld_reg;
    logic [IDX_W-1:0]         idx_a_reg, idx_b_reg;
    logic [SQ_W-1:0]          dx_sq_reg, dy_sq_reg;
    logic signed [SUM_W-1:0]  dx, dy;
    logic signed [2*SUM_W-1:0] dx_sq_full, dy_sq_full;
    logic [DIST_W-1:0]        dist_sq;
    logic                     hit_c;

    nta_match_t               match_cnt_reg, match_cnt_next;
    logic [MAX_TRACKS-1:0]    match_vec_reg, match_vec_next;
    logic [IDX_W-1:0]         hit_reg, hit_next;

    logic                     m_valid_reg, m_valid_next;
    nta_out_t                 m_payload_reg, m_payload_next;
    logic [IDX_W-1:0]         new_idx;

    always_comb begin
        dx         = {cx_reg[CTR_W-1], cx_reg} - {rd_reg[2*CTR_W-1], rd_reg[2*CTR_W-1:CTR_W]};
        dy         = {cy_reg[CTR_W-1], cy_reg} - {rd_reg[CTR_W-1], rd_reg[CTR_W-1:0]};
        dx_sq_full = dx * dx;
        dy_sq_full = dy * dy;
        dist_sq    = {1'b0, dx_sq_reg} + {1'b0, dy_sq_reg};
        hit_c      = b_vld_reg && (dist_sq < {{(DIST_W-THR_SQ_W){1'b0}}, thr_sq_reg});
        new_idx    = count_reg[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_payload;
        end
        if (cmd.start_scan) begin
            cx_reg <= half_centre(in_reg.box_x, in_reg.box_width);
            cy_reg <= half_centre(in_reg.box_y, in_reg.box_height);
        end
        idx_a_reg     <= cmd.scan_idx;
        idx_b_reg     <= idx_a_reg;
        dx_sq_reg     <= dx_sq_full[SQ_W-1:0];
        dy_sq_reg     <= dy_sq_full[SQ_W-1:0];
        m_payload_reg <= m_payload_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            centre_mem[wr_addr] <= {cx_reg, cy_reg};
        end
        rd_reg <= centre_mem[cmd.scan_idx];
    end

    always_comb begin
        thr_sq_next = thr_sq_reg;
        if (cfg_valid) begin
            thr_sq_next = THR_SQ_W'(cfg_data) * THR_SQ_W'(cfg_data);
        end
    end

    always_comb begin
        match_cnt_next = match_cnt_reg;
        match_vec_next = match_vec_reg;
        hit_next       = hit_reg;
        if (cmd.start_scan) begin
            match_cnt_next = MATCH_NONE;
            match_vec_next = '0;
        end else if (hit_c) begin
            match_vec_next[idx_b_reg] = 1'b1;
            hit_next                  = idx_b_reg;
            match_cnt_next = (match_cnt_reg == MATCH_NONE) ? MATCH_ONE : MATCH_MANY;
        end
    end

    always_comb begin
        active_next    = active_reg;
        fresh_next     = fresh_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        wr_en          = 1'b0;
        wr_addr        = hit_reg;
        if (cmd.frame_start) begin
            fresh_next = '0;
        end
        if (cmd.frame_end) begin
            active_next = active_reg & fresh_reg;
        end
        if (cmd.update) begin
            m_valid_next = 1'b1;
            if (match_cnt_reg == MATCH_ONE) begin
                fresh_next[hit_reg]       = 1'b1;
                wr_en                     = 1'b1;
                m_payload_next.track_id   = TID_W'(hit_reg) + TID_W'(1);
                m_payload_next.is_new     = 1'b0;
                m_payload_next.table_full = 1'b0;
            end else begin
                fresh_next = fresh_reg & ~match_vec_reg;
                if (count_reg < CNT_W'(MAX_TRACKS)) begin
                    active_next[new_idx]      = 1'b1;
                    fresh_next[new_idx]       = 1'b1;
                    wr_en                     = 1'b1;
                    wr_addr                   = new_idx;
                    count_next                = count_reg + 1'b1;
                    m_payload_next.track_id   = TID_W'(count_reg) + TID_W'(1);
                    m_payload_next.is_new     = 1'b1;
                    m_payload_next.table_full = 1'b0;
                end else begin
                    m_payload_next.track_id   = '0;
                    m_payload_next.is_new     = 1'b0;
                    m_payload_next.table_full = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_sq_reg    <= THR_SQ_RESET;
            active_reg    <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            match_cnt_reg <= MATCH_NONE;
            match_vec_reg <= '0;
            hit_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            thr_sq_reg    <= thr_sq_next;
            active_reg    <= active_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            a_vld_reg     <= cmd.issue && active_reg[cmd.scan_idx];
            b_vld_reg     <= a_vld_reg;
            match_cnt_reg <= match_cnt_next;
            match_vec_reg <= match_vec_next;
            hit_reg       <= hit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_payload       = m_payload_reg;

endmodule

// ----- design/nearest_track_association.sv -----
// Top level of the nearest track association block: controller and datapath.
// Depends on nta_pkg, nta_ctrl, nta_datapath and the assertion macro header.
//
// Input items arrive on the s_ channel as one struct: an op code and a detection
// box. Frame start and frame end give no result. A detection
// gives one result on the m_ channel: the matched or new track id, a new-track
// flag and a table-full flag. Op code 3 is consumed and ignored.
// A detection occupies the block from its transfer to the next possible input
// transfer while it runs through its centre, slot scan, drain and update steps.
// The slot scan reads one track slot per cycle through a single centre memory
// read port into a two-stage distance pipeline; the update step loads the
// result register that presents the result on the m_ channel.
// The result register lets the next item transfer while a result is waiting. If
// the receiver stalls, a following detection holds in its update step until the
// waiting result has been taken. The cfg_ channel writes the match radius and is
// always ready; the user must write it only while the block is idle, unenforced.
// Reset clears all track marks, the track count and the output valid, and sets
// the radius to 15. The centre memory needs no clearing.
`include "nearest_track_association_macros.svh"

module nearest_track_association
    import nta_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  nta_in_t          s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output nta_out_t         m_payload
);

    nta_cmd_t    cmd;
    nta_status_t status;

    assign cfg_ready = 1'b1;

    nta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_payload.op),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    nta_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

    `NTA_ASSERT_SAME(a_update_free, cmd.update, status.out_free, "Waiting result overwritten.")
    `NTA_ASSERT_NEXT(a_update_shown, cmd.update, m_valid, "Result not presented after update.")
    `NTA_ASSERT_SAME(a_scan_busy, cmd.issue, !s_ready, "Input accepted during slot scan.")
    `NTA_ASSERT_SAME(a_full_result, m_valid && m_payload.table_full, m_payload.track_id == '0 && !m_payload.is_new, "Inconsistent table-full result.")

endmodule

// ----- tb/nearest_track_association_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for nearest_track_association: a queue-fed driver and a
// checking monitor around a cycle-free model of the track table.
// Depends on nta_pkg and the nearest_track_association RTL.
module nearest_track_association_tb;
    import nta_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT   = 300000;
    localparam int         SETTLE_CYCLES = 30;
    localparam int         LONG_STALL    = 600;
    localparam int         MAX_REPORTS   = 10;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data  = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    nta_in_t          s_payload = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    nta_out_t         m_payload;

    nearest_track_association dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // Track table as the block should hold it.
    logic                    trk_active [MAX_TRACKS] = '{default: 1'b0};
    logic                    trk_fresh  [MAX_TRACKS] = '{default: 1'b0};
    logic signed [CTR_W-1:0] trk_cx     [MAX_TRACKS] = '{default: '0};
    logic signed [CTR_W-1:0] trk_cy     [MAX_TRACKS] = '{default: '0};
    logic [CNT_W-1:0]        trk_used     = '0;
    logic [THR_W-1:0]        match_radius = THRESHOLD_RESET;

    nta_in_t  command_queue [$];
    nta_out_t expected_assoc [$];
    int       queued_count   = 0;
    int       error_count    = 0;
    int       cycle_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_idle_pct  = 0;
    bit       long_stall_req = 1'b0;
    int       hold_left      = 0;
    int       target_x [$];
    int       target_y [$];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic signed [CTR_W-1:0] box_centre(
        input logic signed [POS_W-1:0] edge_pos,
        input logic [SIZE_W-1:0]       extent
    );
        int twice;
        twice = 2 * int'(edge_pos) + int'(extent);
        return CTR_W'(twice / 2);
    endfunction

    task automatic update_track_table(input nta_in_t cmd);
        logic signed [CTR_W-1:0] cx, cy;
        logic [MAX_TRACKS-1:0]   near;
        longint                  dx, dy, r2;
        int                      hits, last_hit;
        nta_out_t                res;
        case (cmd.op)
            OP_FRAME_START: begin
                for (int i = 0; i < MAX_TRACKS; i++) trk_fresh[i] = 1'b0;
            end
            OP_FRAME_END: begin
                for (int i = 0; i < MAX_TRACKS; i++)
                    if (!trk_fresh[i]) trk_active[i] = 1'b0;
            end
            OP_DETECT: begin
                cx = box_centre(cmd.box_x, cmd.box_width);
                cy = box_centre(cmd.box_y, cmd.box_height);
                r2 = longint'(match_radius) * longint'(match_radius);
                hits = 0;
                last_hit = 0;
                near = '0;
                for (int i = 0; i < MAX_TRACKS; i++) begin
                    if (trk_active[i]) begin
                        dx = longint'(cx) - longint'(trk_cx[i]);
                        dy = longint'(cy) - longint'(trk_cy[i]);
                        if (dx * dx + dy * dy < r2) begin
                            near[i] = 1'b1;
                            hits++;
                            last_hit = i;
                        end
                    end
                end
                res = '0;
                if (hits == 1) begin
                    trk_fresh[last_hit] = 1'b1;
                    trk_cx[last_hit] = cx;
                    trk_cy[last_hit] = cy;
                    res.track_id = TID_W'(last_hit + 1);
                end else begin
                    for (int i = 0; i < MAX_TRACKS; i++)
                        if (near[i]) trk_fresh[i] = 1'b0;
                    if (trk_used < MAX_TRACKS) begin
                        trk_active[trk_used] = 1'b1;
                        trk_fresh[trk_used] = 1'b1;
                        trk_cx[trk_used] = cx;
                        trk_cy[trk_used] = cy;
                        res.track_id = TID_W'(trk_used + 1);
                        res.is_new = 1'b1;
                        trk_used = trk_used + 1'b1;
                    end else begin
                        res.table_full = 1'b1;
                    end
                end
                expected_assoc.insert(expected_assoc.size(), res);
            end
            default: begin
            end
        endcase
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    task automatic check_result(input nta_out_t got);
        nta_out_t want;
        if (expected_assoc.size() == 0) begin
            note_error($sformatf("tb: result with nothing pending, track_id %0d",
                                 got.track_id));
        end else begin
            want = expected_assoc.pop_front();
            if (got.track_id !== want.track_id)
                note_error($sformatf("tb: track_id got %0d expected %0d",
                                     got.track_id, want.track_id));
            if (got.is_new !== want.is_new)
                note_error($sformatf("tb: is_new got %0b expected %0b",
                                     got.is_new, want.is_new));
            if (got.table_full !== want.table_full)
                note_error($sformatf("tb: table_full got %0b expected %0b",
                                     got.table_full, want.table_full));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                update_track_table(s_payload);
            end
            if (!s_valid || s_ready) begin
                if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_payload <= command_queue.pop_front();
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_payload);
            end
            if (long_stall_req) begin
                hold_left = LONG_STALL;
                long_stall_req = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic int wobble(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic int clamp_pos(input int v);
        return (v < -1800) ? -1800 : ((v > 1800) ? 1800 : v);
    endfunction

    function automatic nta_in_t noise_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(nta_in_t)-1:0];
    endfunction

    function automatic nta_in_t frame_cmd(input logic [1:0] op);
        nta_in_t item;
        item = noise_item();
        item.op = op;
        return item;
    endfunction

    function automatic nta_in_t detection(input int x, input int y, input int w, input int h);
        nta_in_t item;
        item.op         = OP_DETECT;
        item.box_x      = POS_W'(x);
        item.box_y      = POS_W'(y);
        item.box_width  = SIZE_W'(w);
        item.box_height = SIZE_W'(h);
        return item;
    endfunction

    function automatic nta_in_t box_around(input int cx, input int cy);
        int w, h;
        w = $urandom_range(200);
        h = $urandom_range(200);
        return detection(cx - w / 2, cy - h / 2, w, h);
    endfunction

    function automatic void enqueue(input nta_in_t item);
        command_queue.insert(command_queue.size(), item);
        queued_count++;
    endfunction

    function automatic void add_target();
        int k;
        k = target_x.size();
        target_x.insert(target_x.size(), -1700 + 560 * (k % 7) + wobble(40));
        target_y.insert(target_y.size(), -1200 + 1400 * (k / 7) + wobble(40));
    endfunction

    // One frame: every object is seen most of the time and moves a little.
    task automatic queue_frame(input int jitter, input bit close_frame, input int noise_pct);
        int k;
        enqueue(frame_cmd(OP_FRAME_START));
        for (k = 0; k < target_x.size(); k++) begin
            if ($urandom_range(99) < 90) begin
                target_x[k] = clamp_pos(target_x[k] + wobble(jitter));
                target_y[k] = clamp_pos(target_y[k] + wobble(jitter));
                enqueue(box_around(target_x[k], target_y[k]));
            end
        end
        if (target_x.size() < 8 && $urandom_range(99) < 20) add_target();
        if ($urandom_range(99) < noise_pct) enqueue(noise_item());
        if (close_frame) enqueue(frame_cmd(OP_FRAME_END));
    endtask

    task automatic queue_frames(input int count, input int jitter, input bit close_frame,
                                input int noise_pct);
        int first;
        first = queued_count;
        while (queued_count - first < count) queue_frame(jitter, close_frame, noise_pct);
    endtask

    task automatic wait_drained();
        while (command_queue.size() != 0 || s_valid || expected_assoc.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [THR_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        match_radius = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        nta_in_t item;
        int      radius;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 20;
        recv_idle_pct = 85;

        item = detection(2047, -2048, 2047, 0);
        item.op = OP_FRAME_START;
        enqueue(item);
        item = noise_item();
        item.op = OP_UNUSED;
        enqueue(item);
        enqueue(detection(-2048, -2048, 0, 0));
        enqueue(detection(2047, 2047, 2047, 2047));
        // Negative odd sums check truncation toward zero; the repeat matches.
        enqueue(detection(-3, -5, 1, 2));
        enqueue(detection(-3, -5, 1, 2));
        // Two close tracks, then a box between them hits both.
        enqueue(detection(100, 100, 0, 0));
        enqueue(detection(120, 100, 0, 0));
        enqueue(detection(110, 100, 0, 0));
        item = detection(-2048, 2047, 0, 2047);
        item.op = OP_FRAME_END;
        enqueue(item);
        enqueue(frame_cmd(OP_FRAME_START));
        enqueue(detection(110, 100, 0, 0));
        enqueue(frame_cmd(OP_FRAME_END));
        // Exactly on the radius does not match; one pixel inside does.
        enqueue(detection(125, 100, 0, 0));
        enqueue(detection(110, 114, 0, 0));
        wait_drained();

        write_radius(11'd60);
        repeat (5) add_target();
        queue_frames(150, 15, 1'b1, 15);
        long_stall_req = 1'b1;
        wait_drained();

        send_idle_pct = 85;
        recv_idle_pct = 20;
        repeat (2) begin
            radius = $urandom_range(20, 300);
            write_radius(THR_W'(radius));
            queue_frames(70, radius / 4, 1'b1, 30);
            wait_drained();
        end

        write_radius('0);
        queue_frames(40, 10, 1'b0, 30);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_radius({THR_W{1'b1}});
        queue_frames(30, 20, 1'b1, 20);
        wait_drained();
        queue_frames(30, 20, 1'b1, 20);
        wait_drained();

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/nta_pkg.sv
design/nta_ctrl.sv
design/nta_datapath.sv
design/nearest_track_association.sv
tb/nearest_track_association_tb.sv
